// ===== hw/rtl/keccak256_sponge_hash_macros.svh =====
// ----------------------------------------------------------------------------
// keccak256_sponge_hash_macros.svh
// assertion helpers shared by the keccak sponge rtl
// ----------------------------------------------------------------------------
`ifndef KECCAK256_SPONGE_HASH_MACROS_SVH
`define KECCAK256_SPONGE_HASH_MACROS_SVH

// checked only outside reset
`define KEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/kec_pkg.sv =====
// ----------------------------------------------------------------------------
// kec_pkg
// shared types, constants and helpers for the keccak-256 sponge
// ----------------------------------------------------------------------------
package kec_pkg;

    localparam int KEC_RATE_BYTES   = 136;
    localparam int KEC_ROUND_COUNT  = 24;
    localparam int KEC_DIGEST_BYTES = 32;

    localparam logic [7:0] KEC_PAD_FIRST = 8'h01;
    localparam logic [7:0] KEC_PAD_LAST  = 8'h80;

    // round constant lfsr polynomial and seed
    localparam logic [8:0] KEC_LFSR_POLY = 9'h171;
    localparam logic [7:0] KEC_LFSR_SEED = 8'h01;

    // rotation offsets, indexed [x][y]
    localparam int KEC_ROT [5][5] = '{
        '{ 0, 36,  3, 41, 18},
        '{ 1, 44, 10, 45,  2},
        '{62,  6, 43, 15, 61},
        '{28, 55, 25, 21, 56},
        '{27, 20, 39,  8, 14}
    };

    // lane j holds x = j mod 5, y = j / 5
    typedef logic [24:0][63:0] t_lanes;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_PERM,
        S_OUT
    } t_fsm;

    // xor one byte into the state at a little-endian byte position
    function automatic t_lanes kec_xor_byte(input t_lanes s, input logic [7:0] pos,
                                            input logic [7:0] v);
        t_lanes r;
        r = s;
        for (int j = 0; j < 25; j++) begin
            if (pos[7:3] == 5'(j)) begin
                r[j] = r[j] ^ (64'(v) << {pos[2:0], 3'b000});
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/keccak256_sponge_hash.sv =====
// ----------------------------------------------------------------------------
// keccak256_sponge_hash
// keccak-256 sponge (original 0x01 .. 0x80 padding), one message byte a word
// ----------------------------------------------------------------------------
// Accepted input words are absorbed byte by byte into the state. When the
// rate block fills, one keccak-f round runs per cycle in a single shared round
// unit, so the input is held off while the rounds run. The end marker leads to
// a padding step, the rounds, and then the digest words (four at the default
// length), each handed out while the output side is ready. An end word whose
// byte fills the block first waits out that block's rounds, then pads and
// permutes again. The input is ready only while no block is being padded or
// permuted and no digest is being emitted. No clearing pass follows reset: the
// state is cleared in flip-flops at once.
// ----------------------------------------------------------------------------
`include "keccak256_sponge_hash_macros.svh"

module keccak256_sponge_hash #(
    parameter int RATE_BYTES   = kec_pkg::KEC_RATE_BYTES,
    parameter int ROUND_COUNT  = kec_pkg::KEC_ROUND_COUNT,
    parameter int DIGEST_BYTES = kec_pkg::KEC_DIGEST_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    localparam int RND_W     = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam int RAW_WORDS = (DIGEST_BYTES + 7) / 8;
    localparam int NUM_WORDS = (RAW_WORDS > 4) ? 4 : RAW_WORDS;
    localparam int LAST_REM  = DIGEST_BYTES - 8 * (NUM_WORDS - 1);
    localparam logic [63:0] LAST_MASK =
        (LAST_REM >= 8) ? {64{1'b1}} : ((64'd1 << (8 * LAST_REM)) - 64'd1);
    localparam logic [7:0] LAST_POS  = 8'(RATE_BYTES - 1);

    kec_pkg::t_fsm   r_fsm,    n_fsm;
    kec_pkg::t_lanes r_lanes,  n_lanes;
    logic [7:0]      r_offset, n_offset;
    logic [7:0]      r_lfsr,   n_lfsr;
    logic [RND_W-1:0] r_round, n_round;
    logic            r_final,  n_final;
    logic            r_pad,    n_pad;
    logic [1:0]      r_word,   n_word;

    kec_pkg::t_lanes w_round_lanes;
    logic [7:0]      w_round_lfsr;
    kec_pkg::t_lanes w_absorbed;
    logic [63:0]     w_lane;

    kec_round u_round (
        .i_lanes (r_lanes),
        .i_lfsr  (r_lfsr),
        .o_lanes (w_round_lanes),
        .o_lfsr  (w_round_lfsr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= kec_pkg::S_IDLE;
            r_lanes  <= '0;
            r_offset <= '0;
            r_lfsr   <= kec_pkg::KEC_LFSR_SEED;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_pad    <= 1'b0;
            r_word   <= '0;
        end else begin
            r_fsm    <= n_fsm;
            r_lanes  <= n_lanes;
            r_offset <= n_offset;
            r_lfsr   <= n_lfsr;
            r_round  <= n_round;
            r_final  <= n_final;
            r_pad    <= n_pad;
            r_word   <= n_word;
        end
    end

    always_comb begin
        n_fsm      = r_fsm;
        n_lanes    = r_lanes;
        n_offset   = r_offset;
        n_lfsr     = r_lfsr;
        n_round    = r_round;
        n_final    = r_final;
        n_pad      = r_pad;
        n_word     = r_word;
        w_absorbed = i_byte_valid ? kec_pkg::kec_xor_byte(r_lanes, r_offset, i_msg_byte)
                                  : r_lanes;
        unique case (r_fsm)
            kec_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_lanes = w_absorbed;
                    if (i_byte_valid && (r_offset == LAST_POS)) begin
                        // block full: permute, then pad if this was the end
                        n_offset = '0;
                        n_final  = 1'b0;
                        n_pad    = i_end_of_message;
                        n_round  = '0;
                        n_lfsr   = kec_pkg::KEC_LFSR_SEED;
                        n_fsm    = kec_pkg::S_PERM;
                    end else begin
                        if (i_byte_valid) begin
                            n_offset = r_offset + 8'd1;
                        end
                        if (i_end_of_message) begin
                            n_fsm = kec_pkg::S_PAD;
                        end
                    end
                end
            end
            kec_pkg::S_PAD: begin
                n_lanes = kec_pkg::kec_xor_byte(
                    kec_pkg::kec_xor_byte(r_lanes, r_offset, kec_pkg::KEC_PAD_FIRST),
                    LAST_POS, kec_pkg::KEC_PAD_LAST);
                n_offset = '0;
                n_final  = 1'b1;
                n_pad    = 1'b0;
                n_round  = '0;
                n_lfsr   = kec_pkg::KEC_LFSR_SEED;
                n_fsm    = kec_pkg::S_PERM;
            end
            kec_pkg::S_PERM: begin
                n_lanes = w_round_lanes;
                n_lfsr  = w_round_lfsr;
                if (r_round == RND_W'(ROUND_COUNT - 1)) begin
                    n_word = '0;
                    n_fsm  = r_final ? kec_pkg::S_OUT
                                     : (r_pad ? kec_pkg::S_PAD : kec_pkg::S_IDLE);
                end else begin
                    n_round = r_round + RND_W'(1);
                end
            end
            kec_pkg::S_OUT: begin
                if (i_out_ready) begin
                    if (r_word == 2'(NUM_WORDS - 1)) begin
                        // digest delivered: fresh state for the next message
                        n_lanes  = '0;
                        n_offset = '0;
                        n_final  = 1'b0;
                        n_fsm    = kec_pkg::S_IDLE;
                    end else begin
                        n_word = r_word + 2'd1;
                    end
                end
            end
            default: begin
                n_fsm = kec_pkg::S_IDLE;
            end
        endcase
    end

    assign w_lane        = r_lanes[{3'b000, r_word}];
    assign o_in_ready    = (r_fsm == kec_pkg::S_IDLE);
    assign o_out_valid   = (r_fsm == kec_pkg::S_OUT);
    assign o_word_index  = r_word;
    assign o_last_word   = (r_word == 2'(NUM_WORDS - 1));
    assign o_digest_word = o_last_word ? (w_lane & LAST_MASK) : w_lane;

    `KEC_ASSERT_ALWAYS(a_ready_vs_valid, i_clk, (!i_rst_n || !(o_in_ready && o_out_valid)), "in ready during digest output")
    `KEC_ASSERT(a_offset_range, i_clk, i_rst_n, (r_offset < 8'(RATE_BYTES)), "block offset past rate")
    `KEC_ASSERT(a_done_clears, i_clk, i_rst_n, (o_out_valid && i_out_ready && o_last_word) |=> (o_in_ready && (r_offset == 8'd0) && (r_lanes == '0)), "state not cleared after digest")
    `KEC_ASSERT(a_word_step, i_clk, i_rst_n, (o_out_valid && i_out_ready && !o_last_word) |=> (o_out_valid && (o_word_index == $past(o_word_index) + 2'd1)), "digest word order broken")

endmodule

// ===== hw/rtl/kec_round.sv =====
// ----------------------------------------------------------------------------
// kec_round
// one keccak-f[1600] round: theta, rho, pi, chi, iota
// ----------------------------------------------------------------------------
module kec_round (
    input  kec_pkg::t_lanes i_lanes,
    input  logic [7:0]      i_lfsr,
    output kec_pkg::t_lanes o_lanes,
    output logic [7:0]      o_lfsr
);

    function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
        logic [5:0] s;
        s = 6'(n);
        return (s == 6'd0) ? v : ((v << s) | (v >> (7'd64 - {1'b0, s})));
    endfunction

    logic [4:0][63:0] c;
    kec_pkg::t_lanes  a;
    kec_pkg::t_lanes  b;
    kec_pkg::t_lanes  chi;
    logic [7:0]       lfsr;

    always_comb begin
        // theta
        for (int x = 0; x < 5; x++) begin
            c[x] = i_lanes[x] ^ i_lanes[x + 5] ^ i_lanes[x + 10] ^ i_lanes[x + 15]
                   ^ i_lanes[x + 20];
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                a[x + 5 * y] = i_lanes[x + 5 * y] ^ c[(x + 4) % 5] ^ rol64(c[(x + 1) % 5], 1);
            end
        end
        // rho and pi
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                b[y + 5 * ((2 * x + 3 * y) % 5)] = rol64(a[x + 5 * y], kec_pkg::KEC_ROT[x][y]);
            end
        end
        // chi
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                chi[x + 5 * y] = b[x + 5 * y]
                                 ^ (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
            end
        end
        // iota, seven lfsr steps per round
        lfsr = i_lfsr;
        for (int k = 0; k < 7; k++) begin
            chi[0][(1 << k) - 1] = chi[0][(1 << k) - 1] ^ lfsr[0];
            lfsr = {lfsr[6:0], 1'b0} ^ (lfsr[7] ? kec_pkg::KEC_LFSR_POLY[7:0] : 8'h00);
        end
        o_lanes = chi;
        o_lfsr  = lfsr;
    end

endmodule
